// ===== hw/rtl/eloc_pkg.sv =====
// shared types and constants for the event loop offset check
`timescale 1ns / 1ps
`default_nettype none

package eloc_pkg;

    localparam int IDX_W      = 13;
    localparam int SEC_LEN_W  = 12;
    localparam int REM_W      = 14;
    localparam int NIB_W      = 4;
    localparam int OFS_W      = 4;

    localparam int HDR_BYTES      = 12;
    localparam int MAX_LOOP_BYTES = 4096;
    localparam int DLEN_HI_POS    = 10;
    localparam int DLEN_LO_POS    = 11;

    localparam logic [OFS_W-1:0] OFS_PRIMARY   = OFS_W'(14);
    localparam logic [OFS_W-1:0] OFS_SECONDARY = OFS_W'(13);
    localparam logic [OFS_W-1:0] OFS_NONE      = '0;

    localparam logic [IDX_W-1:0] IDX_LEN_HI = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LEN_LO = IDX_W'(2);

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [SEC_LEN_W-1:0]    sec_len_t;
    typedef logic signed [REM_W-1:0] rem_t;

    typedef struct packed {
        logic     adv;
        logic     load;
        logic     walk;
        logic     clear;
        idx_t     idx;
        logic [7:0] data;
        sec_len_t sec_len;
    } trk_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/eloc_tracker.sv =====
// one event loop walker for a single candidate start offset
`timescale 1ns / 1ps
`default_nettype none

module eloc_tracker
    import eloc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire trk_ctl_t ctl,
    input  wire idx_t     start_pos,
    output logic          done_ok
);

    idx_t                   pos_reg, pos_next;
    rem_t                   rem_reg, rem_next;
    logic [NIB_W-1:0]       nib_reg, nib_next;
    logic                   alive_reg, alive_next;

    idx_t                   pos_proc;
    rem_t                   rem_proc;
    logic [NIB_W-1:0]       nib_proc;
    logic                   alive_proc;

    rem_t                   rem_load;
    rem_t                   rem_sub;
    idx_t                   pos_add;
    logic [SEC_LEN_W-1:0]   dlen;
    logic [REM_W-1:0]       dlen_ext;
    logic                   walk_act;
    logic                   hit_hi;
    logic                   hit_lo;
    logic                   too_long;

    function automatic logic judge_ok(rem_t r);
        logic bad;
        bad = (r < 0) || (r >= $signed(REM_W'(MAX_LOOP_BYTES)))
            || ((r > 0) && (r < $signed(REM_W'(HDR_BYTES))));
        return !bad;
    endfunction

    assign dlen     = {nib_reg, ctl.data};
    assign dlen_ext = {{(REM_W-SEC_LEN_W){1'b0}}, dlen};
    assign rem_load = $signed({{(REM_W-SEC_LEN_W){1'b0}}, ctl.sec_len})
                    - $signed({{(REM_W-IDX_W){1'b0}}, start_pos})
                    - $signed(REM_W'(1));
    assign rem_sub  = rem_reg - $signed(REM_W'(HDR_BYTES) + dlen_ext);
    assign pos_add  = pos_reg + IDX_W'(HDR_BYTES) + IDX_W'(dlen);
    assign walk_act = ctl.walk && alive_reg && (rem_reg > 0);
    assign hit_hi   = {1'b0, ctl.idx} == ({1'b0, pos_reg} + (IDX_W+1)'(DLEN_HI_POS));
    assign hit_lo   = {1'b0, ctl.idx} == ({1'b0, pos_reg} + (IDX_W+1)'(DLEN_LO_POS));
    assign too_long = $signed(dlen_ext) > rem_reg;

    // apply the current byte
    always_comb
    begin
        pos_proc   = pos_reg;
        rem_proc   = rem_reg;
        nib_proc   = nib_reg;
        alive_proc = alive_reg;
        if (ctl.load)
        begin
            rem_proc   = rem_load;
            alive_proc = alive_reg && judge_ok(rem_load);
        end
        else if (walk_act)
        begin
            if (hit_hi)
            begin
                nib_proc = ctl.data[NIB_W-1:0];
            end
            else if (hit_lo)
            begin
                if (too_long)
                begin
                    alive_proc = 1'b0;
                end
                else
                begin
                    rem_proc   = rem_sub;
                    pos_proc   = pos_add;
                    alive_proc = judge_ok(rem_sub);
                end
            end
        end
    end

    assign done_ok = alive_proc && (rem_proc == 0);

    // end of section returns to the idle values
    always_comb
    begin
        if (ctl.clear)
        begin
            pos_next   = start_pos;
            rem_next   = '0;
            nib_next   = '0;
            alive_next = 1'b1;
        end
        else
        begin
            pos_next   = pos_proc;
            rem_next   = rem_proc;
            nib_next   = nib_proc;
            alive_next = alive_proc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= start_pos;
            rem_reg   <= '0;
            nib_reg   <= '0;
            alive_reg <= 1'b1;
        end
        else if (ctl.adv)
        begin
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            nib_reg   <= nib_next;
            alive_reg <= alive_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/eit_event_loop_offset_check_core.sv =====
// top level of the event information table event loop offset check
// takes one section byte per request on the slave side and, on the byte marked
// tlast, returns one result request: the event loop offset (14 or 13, 14 checked
// first) with found set, or offset 0 with found clear when neither candidate
// walks the event headers to exactly the section end. one byte is accepted
// every cycle unless a last byte waits behind an untaken result. a last byte sits
// in the input register, and the tracker update loads the result register as that
// byte leaves it. the result register lets input keep flowing while a result waits;
// only a second last byte arriving behind an untaken result holds the input.
// after each result all internal state is back at its idle values, so sections
// may follow one another directly. no configuration, no start-up sweep.
`timescale 1ns / 1ps
`default_nettype none

module eit_event_loop_offset_check_core
    import eloc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [3:0] loop_offset, [4] found, [7:5] zero
);

    // input register
    logic       s1_vld_reg, s1_vld_next;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       s1_adv;
    logic       in_acc;

    // section position and length
    idx_t     idx_reg, idx_next;
    sec_len_t sl_reg, sl_next;

    // result register
    logic             out_vld_reg, out_vld_next;
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic             found_reg, found_next;

    trk_ctl_t ctl;
    logic     ok_primary;
    logic     ok_secondary;
    logic     past_len;

    // a byte leaves the input register unless it is a last byte facing a full result slot that is not taken
    assign s1_adv        = s1_vld_reg && (!s1_last_reg || !out_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s1_vld_next   = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_reg);

    assign past_len = idx_reg > IDX_LEN_LO;

    assign ctl.adv     = s1_adv;
    assign ctl.load    = idx_reg == IDX_LEN_LO;
    assign ctl.walk    = past_len;
    assign ctl.clear   = s1_last_reg;
    assign ctl.idx     = idx_reg;
    assign ctl.data    = s1_data_reg;
    assign ctl.sec_len = sl_reg | {{(SEC_LEN_W-8){1'b0}}, s1_data_reg};

    eloc_tracker u_trk_primary (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .start_pos (IDX_W'(OFS_PRIMARY)),
        .done_ok   (ok_primary)
    );

    eloc_tracker u_trk_secondary (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .start_pos (IDX_W'(OFS_SECONDARY)),
        .done_ok   (ok_secondary)
    );

    // byte counter saturates, length taken from bytes 1 and 2
    always_comb
    begin
        idx_next = (idx_reg == '1) ? idx_reg : idx_reg + IDX_W'(1);
        sl_next  = sl_reg;
        if (idx_reg == IDX_LEN_HI)
        begin
            sl_next = {s1_data_reg[NIB_W-1:0], 8'h00};
        end
        else if (idx_reg == IDX_LEN_LO)
        begin
            sl_next = ctl.sec_len;
        end
        if (s1_last_reg)
        begin
            idx_next = '0;
            sl_next  = '0;
        end
    end

    // primary offset wins when both candidates close
    always_comb
    begin
        ofs_next   = ofs_reg;
        found_next = found_reg;
        if (s1_adv && s1_last_reg)
        begin
            if (past_len && ok_primary)
            begin
                ofs_next = OFS_PRIMARY;
            end
            else if (past_len && ok_secondary)
            begin
                ofs_next = OFS_SECONDARY;
            end
            else
            begin
                ofs_next = OFS_NONE;
            end
            found_next = past_len && (ok_primary || ok_secondary);
        end
    end

    always_comb
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            idx_reg     <= '0;
            sl_reg      <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            if (s1_adv)
            begin
                idx_reg <= idx_next;
                sl_reg  <= sl_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_data_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
        ofs_reg   <= ofs_next;
        found_reg <= found_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {3'b000, found_reg, ofs_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/eloc_checker.sv =====
// port-level checks for the event loop offset check, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module eloc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // a stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result request changed while stalled");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
        else $error("result pad bits set");

    // found agrees with the offset
    a_found_ofs: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[4] && (m_axis_tdata[3:0] == 4'd14 || m_axis_tdata[3:0] == 4'd13))
            || (!m_axis_tdata[4] && m_axis_tdata[3:0] == 4'd0))
        else $error("found flag and offset disagree");

    // a result is only loaded in a cycle where the last byte moves on, so input is open
    a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tready))
        else $error("result appeared from nowhere");

endmodule

bind eit_event_loop_offset_check_core eloc_checker u_eloc_checker (.*);

`default_nettype wire

// ===== tb/sv/eit_event_loop_offset_check_core_tb.sv =====
// testbench for eit_event_loop_offset_check_core: built sections against a tracker predictor
`timescale 1ns / 1ps

module eit_event_loop_offset_check_core_tb;
    import eloc_pkg::*;

    // start offsets and typed answers used in the stimulus table
    localparam int LOOP_AT_14 = int'(OFS_PRIMARY);
    localparam int LOOP_AT_13 = int'(OFS_SECONDARY);
    localparam int NO_LOOP    = int'(OFS_NONE);
    localparam int RAW        = 0;     // no event layout, bytes are random
    localparam int PREDICTED  = -1;    // answer comes from the predictor

    localparam int MAX_SEC_LEN    = (1 << SEC_LEN_W) - 1;
    localparam int LEN_FIELD_END  = 3;   // table id plus the two length bytes
    localparam int NUM_DIRECTED   = 20;
    localparam int PHASE_BYTES    = 60;
    localparam int PHASE_SECTIONS = 2;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int CYCLE_LIMIT    = 500000;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] loop_offset;
    } offset_result_t;

    // start: LOOP_AT_14 / LOOP_AT_13 lays out well-formed events from there, RAW does not
    // len_field: added to the natural section length, or the length itself for RAW
    // n_bytes: bytes sent, 0 means the natural section size
    typedef struct packed {
        int start;
        int n_events;
        int dlen_lo;
        int dlen_hi;
        int len_field;
        int n_bytes;
        int want;
    } section_row_t;

    localparam section_row_t DIRECTED [NUM_DIRECTED] = '{
        '{RAW,        0, 0,    0,    100,  1,    NO_LOOP},     // ends on table id
        '{RAW,        0, 0,    0,    100,  2,    NO_LOOP},     // ends on length high byte
        '{RAW,        0, 0,    0,    100,  3,    NO_LOOP},     // ends on length low byte
        '{LOOP_AT_14, 0, 0,    0,    0,    0,    LOOP_AT_14},  // empty loop at 14
        '{LOOP_AT_13, 0, 0,    0,    0,    0,    LOOP_AT_13},  // empty loop at 13
        '{RAW,        0, 0,    0,    0,    20,   NO_LOOP},     // zero length, both negative
        '{RAW,        0, 0,    0,    20,   40,   NO_LOOP},     // less than a header left
        '{RAW,        0, 0,    0,    4095, 20,   NO_LOOP},     // longest length, cut short
        '{LOOP_AT_14, 1, 0,    0,    0,    0,    LOOP_AT_14},  // one event, no descriptors
        '{LOOP_AT_14, 1, 4068, 4068, 0,    30,   LOOP_AT_14},  // longest length, ends after header
        '{LOOP_AT_14, 1, 256,  256,  0,    30,   LOOP_AT_14},  // dlen into the high nibble
        '{LOOP_AT_13, 2, 0,    8,    0,    0,    PREDICTED},
        '{LOOP_AT_13, 3, 0,    4,    0,    0,    PREDICTED},
        '{LOOP_AT_14, 1, 30,   30,   -13,  30,   PREDICTED},   // dlen beyond what is left
        '{LOOP_AT_14, 2, 0,    0,    5,    0,    PREDICTED},   // length too long
        '{LOOP_AT_14, 1, 8,    8,    0,    24,   NO_LOOP},     // header bytes 10, 11 missing
        '{LOOP_AT_14, 1, 8,    8,    0,    25,   PREDICTED},   // header byte 11 missing
        '{LOOP_AT_14, 2, 0,    4,    -1,   0,    PREDICTED},   // length one short
        '{LOOP_AT_13, 1, 4069, 4069, 0,    30,   PREDICTED},
        '{RAW,        0, 0,    0,    2047, 30,   PREDICTED}    // mid length, random bytes
    };

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    eit_event_loop_offset_check_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] data_byte
        .s_axis_tlast  (s_axis_tlast),    // last_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)     // [3:0] loop_offset, [4] found, [7:5] zero
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // predictor state: one byte position, the length field, two candidate walkers
    idx_t        sec_pos;
    sec_len_t    sec_len_field;
    idx_t        hdr_start   [2];
    rem_t        loop_left   [2];
    logic [3:0]  dlen_hi_nib [2];
    bit          cand_ok     [2];

    offset_result_t offset_queue [$];
    int             section_wants [$];
    logic [7:0]     section_bytes [$];

    int mismatches    = 0;
    int cycles        = 0;
    int bytes_sent    = 0;
    int src_idle_pct  = 30;
    int sink_idle_pct = 59;

    function automatic void reset_candidates();
        sec_pos        = '0;
        sec_len_field  = '0;
        hdr_start[0]   = idx_t'(OFS_PRIMARY);
        hdr_start[1]   = idx_t'(OFS_SECONDARY);
        for (int t = 0; t < 2; t++) begin
            loop_left[t]   = '0;
            dlen_hi_nib[t] = '0;
            cand_ok[t]     = 1'b1;
        end
    endfunction

    // a walker dies on a negative count, an impossible count or a partial header
    function automatic void check_remaining(input int t);
        int r;
        r = int'(loop_left[t]);
        if (r < 0 || r >= MAX_LOOP_BYTES)
            cand_ok[t] = 1'b0;
        else if (r > 0 && r < HDR_BYTES)
            cand_ok[t] = 1'b0;
    endfunction

    function automatic void walk_candidate(input int t, input idx_t idx, input logic [7:0] b);
        int dlen;
        if (!cand_ok[t] || loop_left[t] <= 0)
            return;
        if (int'(idx) == int'(hdr_start[t]) + DLEN_HI_POS) begin
            dlen_hi_nib[t] = b[3:0];
        end
        else if (int'(idx) == int'(hdr_start[t]) + DLEN_LO_POS) begin
            dlen = int'({dlen_hi_nib[t], b});
            if (dlen > int'(loop_left[t])) begin
                cand_ok[t] = 1'b0;
                return;
            end
            loop_left[t] = rem_t'(int'(loop_left[t]) - HDR_BYTES - dlen);
            hdr_start[t] = idx_t'(int'(hdr_start[t]) + HDR_BYTES + dlen);
            check_remaining(t);
        end
    endfunction

    // returns 1 when the byte closes a section, with the predicted answer in res
    function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                        output offset_result_t res);
        idx_t idx;
        idx = sec_pos;
        res = '{found: 1'b0, loop_offset: OFS_NONE};
        if (idx == IDX_LEN_HI) begin
            sec_len_field = {b[3:0], 8'h00};
        end
        else if (idx == IDX_LEN_LO) begin
            sec_len_field = sec_len_field | sec_len_t'(b);
            loop_left[0]  = rem_t'(int'(sec_len_field) - 1 - int'(OFS_PRIMARY));
            loop_left[1]  = rem_t'(int'(sec_len_field) - 1 - int'(OFS_SECONDARY));
            check_remaining(0);
            check_remaining(1);
        end
        else if (idx > IDX_LEN_LO) begin
            walk_candidate(0, idx, b);
            walk_candidate(1, idx, b);
        end
        if (sec_pos != '1)
            sec_pos = sec_pos + 1'b1;
        if (!last)
            return 1'b0;
        // 14 wins over 13 when both land on zero
        if (idx > IDX_LEN_LO) begin
            for (int t = 0; t < 2; t++) begin
                if (cand_ok[t] && loop_left[t] == 0) begin
                    res.loop_offset = (t == 0) ? OFS_PRIMARY : OFS_SECONDARY;
                    res.found       = 1'b1;
                    break;
                end
            end
        end
        reset_candidates();
        return 1'b1;
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic last);
        offset_result_t res;
        int want;
        if (!predict_byte(b, last, res))
            return;
        want = section_wants.pop_front();
        if (want != PREDICTED) begin
            res.loop_offset = OFS_W'(want);
            res.found       = (want != NO_LOOP);
        end
        offset_queue.push_back(res);
    endfunction

    function automatic void check_result(input logic [7:0] word);
        offset_result_t exp;
        if (offset_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: offset %0d found %0b",
                         word[OFS_W-1:0], word[OFS_W]);
            return;
        end
        exp = offset_queue.pop_front();
        if (word[OFS_W-1:0] != exp.loop_offset || word[OFS_W] != exp.found) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: expected offset %0d found %0b, got offset %0d found %0b",
                         exp.loop_offset, exp.found, word[OFS_W-1:0], word[OFS_W]);
        end
    endfunction

    // result side is checked before the input side so a same-edge push is never popped
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("eit_event_loop_offset_check_core_tb: errors");
            $finish;
        end
    end

    // lay out one section: length field, then event headers with their descriptor lengths
    task automatic build_section(input section_row_t row);
        int n;
        int sec_len;
        int pos;
        int d;
        int dlens [$];
        logic [SEC_LEN_W-1:0] len_bits;
        logic [SEC_LEN_W-1:0] d_bits;
        section_bytes.delete();
        if (row.start == RAW) begin
            sec_len = row.len_field;
            n       = row.n_bytes;
        end
        else begin
            sec_len = row.start + 1;
            for (int e = 0; e < row.n_events; e++) begin
                d = $urandom_range(row.dlen_hi, row.dlen_lo);
                if (sec_len + HDR_BYTES + d > MAX_SEC_LEN)
                    break;
                dlens.push_back(d);
                sec_len += HDR_BYTES + d;
            end
            n = (row.n_bytes > 0) ? row.n_bytes : sec_len + LEN_FIELD_END;
            sec_len += row.len_field;
        end
        for (int i = 0; i < n; i++)
            section_bytes.push_back(8'($urandom_range(255)));
        len_bits = SEC_LEN_W'(sec_len);
        if (n > 1)
            section_bytes[1] = {4'($urandom_range(15)), len_bits[11:8]};
        if (n > 2)
            section_bytes[2] = len_bits[7:0];
        pos = row.start;
        foreach (dlens[e]) begin
            d_bits = SEC_LEN_W'(dlens[e]);
            if (pos + DLEN_HI_POS < n)
                section_bytes[pos + DLEN_HI_POS] = {4'($urandom_range(15)), d_bits[11:8]};
            if (pos + DLEN_LO_POS < n)
                section_bytes[pos + DLEN_LO_POS] = d_bits[7:0];
            pos += HDR_BYTES + dlens[e];
        end
    endtask

    // one byte request; returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_section(input section_row_t row, input int keep);
        build_section(row);
        if (keep > 0)
            while (section_bytes.size() > keep)
                void'(section_bytes.pop_back());
        section_wants.push_back(row.want);
        foreach (section_bytes[i])
            send_byte(section_bytes[i], i == section_bytes.size() - 1);
    endtask

    // mostly well-formed event loops with random content, some noise and cut sections
    task automatic send_random_section();
        section_row_t row;
        int kind;
        int keep;
        kind = $urandom_range(99);
        row  = '{RAW, 0, 0, 0, 0, 0, PREDICTED};
        keep = 0;
        if (kind < 65) begin
            row.start    = $urandom_range(1) ? LOOP_AT_14 : LOOP_AT_13;
            row.n_events = $urandom_range(3);
            row.dlen_hi  = ($urandom_range(9) == 0) ? 64 : 12;
            case ($urandom_range(7))
                0:       row.len_field = int'($urandom_range(6)) - 3;
                1:       row.len_field = -int'($urandom_range(40, 1));
                default: row.len_field = 0;
            endcase
            build_section(row);
            if ($urandom_range(7) == 0)
                keep = $urandom_range(section_bytes.size(), 1);
        end
        else if (kind < 90) begin
            row.len_field = $urandom_range(1) ? $urandom_range(MAX_SEC_LEN) : $urandom_range(80);
            row.n_bytes   = $urandom_range(40, 4);
        end
        else begin
            row.len_field = $urandom_range(MAX_SEC_LEN);
            row.n_bytes   = $urandom_range(3, 1);
        end
        send_section(row, keep);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct);
        int start_bytes;
        int n_sections;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start_bytes   = bytes_sent;
        n_sections    = 0;
        while (bytes_sent - start_bytes < PHASE_BYTES || n_sections < PHASE_SECTIONS) begin
            send_random_section();
            n_sections++;
        end
    endtask

    // drop the request and wait until every pending result is back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        do
            @(posedge clk);
        while (offset_queue.size() != 0);
    endtask

    initial begin
        reset_candidates();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_section(DIRECTED[i], 0);
        hold_until_drained();

        run_phase(30, 59);
        run_phase(59, 30);
        run_phase(0, 0);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("eit_event_loop_offset_check_core_tb: clean");
        else
            $display("eit_event_loop_offset_check_core_tb: errors");
        $finish;
    end

endmodule
